### design/bgc_pkg.sv
// ----------------------------------------------------------------------------
// bgc_pkg
// Shared types and constants of the button gesture classifier.
// ----------------------------------------------------------------------------
package bgc_pkg;

  // stream widths, fields packed from bit 0 and zero-filled to whole bytes
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int STAMP_W     = 32;

  // register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_TIME   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DOUBLE_WINDOW   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS_TIME = 2'd2;

  // register reset values in milliseconds
  localparam logic [CFG_DATA_W-1:0] DEBOUNCE_TIME_RST   = 16'd50;
  localparam logic [CFG_DATA_W-1:0] DOUBLE_WINDOW_RST   = 16'd300;
  localparam logic [CFG_DATA_W-1:0] LONG_PRESS_TIME_RST = 16'd1000;

  // active-low button levels
  localparam logic LVL_PRESSED  = 1'b0;
  localparam logic LVL_RELEASED = 1'b1;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] debounce_time;
    logic [CFG_DATA_W-1:0] double_click_window;
    logic [CFG_DATA_W-1:0] long_press_time;
  } cfg_t;

  typedef struct packed {
    logic               clear_all;
    logic               ack_long;
    logic               ack_double;
    logic               ack_click;
    logic [STAMP_W-1:0] now_ms;
    logic               button_level;
  } item_t;

  typedef struct packed {
    logic               prev_raw_level;
    logic               steady_level;
    logic [STAMP_W-1:0] change_stamp;
    logic [STAMP_W-1:0] press_stamp;
    logic               long_armed;
    logic [STAMP_W-1:0] click_stamp;
    logic               click_pending;
    logic               click_flag;
    logic               double_flag;
    logic               long_flag;
  } state_t;

  // button state after reset: both levels released, everything else zero
  localparam state_t STATE_RST = state_t'({LVL_RELEASED, LVL_RELEASED,
                                           {($bits(state_t)-2){1'b0}}});

endpackage

### design/bgc_step.sv
// ----------------------------------------------------------------------------
// bgc_step
// Next-state logic for one button poll: acknowledges and clear, debounce, click,
// double click and long press detection.
// ----------------------------------------------------------------------------
module bgc_step (
  input  bgc_pkg::state_t state_q,
  input  bgc_pkg::item_t  item,
  input  bgc_pkg::cfg_t   cfg,
  output bgc_pkg::state_t state_d
);

  always_comb begin
    bgc_pkg::state_t                s;
    logic [bgc_pkg::STAMP_W-1:0]    since_change;
    logic [bgc_pkg::STAMP_W-1:0]    since_click;
    logic [bgc_pkg::STAMP_W-1:0]    since_press;
    logic [bgc_pkg::STAMP_W-1:0]    since_click2;

    s = state_q;

    // acknowledges and clear act before the sample
    if (item.ack_click)  s.click_flag  = 1'b0;
    if (item.ack_double) s.double_flag = 1'b0;
    if (item.ack_long)   s.long_flag   = 1'b0;
    if (item.clear_all) begin
      s.click_flag    = 1'b0;
      s.double_flag   = 1'b0;
      s.long_flag     = 1'b0;
      s.click_pending = 1'b0;
      s.click_stamp   = '0;
      s.press_stamp   = '0;
      s.long_armed    = 1'b0;
    end

    // raw change restarts the debounce timer
    if (item.button_level != s.prev_raw_level) s.change_stamp = item.now_ms;

    // debounce acceptance, press opens a click or completes a double click
    since_change = item.now_ms - s.change_stamp;
    since_click  = item.now_ms - s.click_stamp;
    if ((since_change > {16'd0, cfg.debounce_time}) &&
        (item.button_level != s.steady_level)) begin
      s.steady_level = item.button_level;
      if (item.button_level == bgc_pkg::LVL_PRESSED) begin
        s.press_stamp = item.now_ms;
        s.long_armed  = 1'b1;
        if (s.click_pending && (since_click < {16'd0, cfg.double_click_window})) begin
          s.double_flag   = 1'b1;
          s.click_pending = 1'b0;
          s.click_stamp   = '0;
        end else begin
          s.click_pending = 1'b1;
          s.click_stamp   = item.now_ms;
        end
      end
    end

    // long hold fires once per press
    since_press = item.now_ms - s.press_stamp;
    if ((s.steady_level == bgc_pkg::LVL_PRESSED) && s.long_armed &&
        (since_press >= {16'd0, cfg.long_press_time})) begin
      s.long_flag     = 1'b1;
      s.click_pending = 1'b0;
      s.long_armed    = 1'b0;
      s.press_stamp   = '0;
    end

    // pending click confirmed after release once the window expires
    since_click2 = item.now_ms - s.click_stamp;
    if (s.click_pending && (s.steady_level == bgc_pkg::LVL_RELEASED) &&
        (since_click2 >= {16'd0, cfg.double_click_window})) begin
      s.click_flag    = 1'b1;
      s.click_pending = 1'b0;
    end

    s.prev_raw_level = item.button_level;
    state_d = s;
  end

endmodule

### design/button_gesture_classifier.sv
// Path: an accepted item waits in the input register and is stepped into the
// result register once that register is free (input register, then result
// register). Throughput: one item per cycle while the result side is not
// stalled; bgc_step is combinational. in_tready drops only while the input
// register is full and the result register holds a stalled item.
// Reset (rst_n low, synchronous): registers back to 50/300/1000 ms, button
// state to released, all flags, pending click and long press arming cleared.
// ----------------------------------------------------------------------------
// button_gesture_classifier
// Debounced push-button classifier reporting sticky click, double click and
// long press flags per poll.
// ----------------------------------------------------------------------------
module button_gesture_classifier (
  input  logic                                clk,
  input  logic                                rst_n,
  // config write port
  input  logic                                cfg_wr_en,
  input  logic [bgc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [bgc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [0] button_level, [32:1] now_ms, [33] ack_click, [34] ack_double,
  // [35] ack_long, [36] clear_all, [39:37] zero
  input  logic [bgc_pkg::IN_TDATA_W-1:0]      in_tdata,
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] click_event, [1] double_click_event, [2] long_press_event,
  // [3] debounced_level, [7:4] zero
  output logic [bgc_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  bgc_pkg::cfg_t   cfg_r;
  bgc_pkg::state_t state_r;
  bgc_pkg::state_t state_nxt;
  bgc_pkg::item_t  item_r;
  logic            s1_valid_r;
  logic            out_valid_r;
  logic [bgc_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic            adv;
  logic            in_fire;
  logic            s1_fire;

  // handshake: input register advances whenever the result register frees
  assign adv       = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && adv;
  assign in_tready = !s1_valid_r || adv;
  assign in_fire   = in_tvalid && in_tready;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_time       <= bgc_pkg::DEBOUNCE_TIME_RST;
      cfg_r.double_click_window <= bgc_pkg::DOUBLE_WINDOW_RST;
      cfg_r.long_press_time     <= bgc_pkg::LONG_PRESS_TIME_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        bgc_pkg::CFG_DEBOUNCE_TIME:   cfg_r.debounce_time       <= cfg_wdata;
        bgc_pkg::CFG_DOUBLE_WINDOW:   cfg_r.double_click_window <= cfg_wdata;
        bgc_pkg::CFG_LONG_PRESS_TIME: cfg_r.long_press_time     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= bgc_pkg::item_t'(in_tdata[$bits(bgc_pkg::item_t)-1:0]);
    end
  end

  // per-poll state update
  bgc_step u_step (
    .state_q (state_r),
    .item    (item_r),
    .cfg     (cfg_r),
    .state_d (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bgc_pkg::STATE_RST;
    end else if (s1_fire) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r <= {4'd0, state_nxt.steady_level, state_nxt.long_flag,
                     state_nxt.double_flag, state_nxt.click_flag};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv) |=> s1_valid_r)
    else $error("input register dropped a stalled item");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("stepped item produced no result");

  a_state_only_on_step: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !s1_fire) |=> $stable(state_r))
    else $error("button state changed without a step");

  a_long_when_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r.long_flag) |-> (state_r.steady_level == bgc_pkg::LVL_PRESSED))
    else $error("long press flagged while released");

  a_click_when_released: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r.click_flag) |-> (state_r.steady_level == bgc_pkg::LVL_RELEASED))
    else $error("click confirmed while pressed");

endmodule

### test/button_gesture_classifier_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_gesture_classifier_tb
// Drives button polls over the input stream and checks each flag item against
// a cycle-free model of the debouncer and gesture logic. Runs directed edge
// cases, then random press/release gestures with bounce, timestamp jumps and
// acknowledges under several register settings, with random idling on both
// streams.
// ----------------------------------------------------------------------------
module button_gesture_classifier_tb;

  // one result item, click_event in bit 0
  typedef struct packed {
    logic debounced_level;
    logic long_press_event;
    logic double_click_event;
    logic click_event;
  } flags_t;

  // model of the classifier plus the queue of flags still owed by the block
  class gesture_scoreboard;
    bgc_pkg::cfg_t   cfg;
    bgc_pkg::state_t st;
    flags_t          expected_flags[$];
    int              errors;

    function new();
      cfg.debounce_time       = bgc_pkg::DEBOUNCE_TIME_RST;
      cfg.double_click_window = bgc_pkg::DOUBLE_WINDOW_RST;
      cfg.long_press_time     = bgc_pkg::LONG_PRESS_TIME_RST;
      st                      = '0;
      st.prev_raw_level       = bgc_pkg::LVL_RELEASED;
      st.steady_level         = bgc_pkg::LVL_RELEASED;
      errors                  = 0;
    endfunction

    // zero-extend a register value to timestamp width
    function logic [bgc_pkg::STAMP_W-1:0] widen(input logic [bgc_pkg::CFG_DATA_W-1:0] v);
      return {{(bgc_pkg::STAMP_W-bgc_pkg::CFG_DATA_W){1'b0}}, v};
    endfunction

    // advance the model by one accepted poll
    function void note_poll(input bgc_pkg::item_t it);
      logic [bgc_pkg::STAMP_W-1:0] age;
      flags_t                      res;
      // acknowledges and clear act before the sample
      if (it.ack_click)  st.click_flag  = 1'b0;
      if (it.ack_double) st.double_flag = 1'b0;
      if (it.ack_long)   st.long_flag   = 1'b0;
      if (it.clear_all) begin
        st.click_flag    = 1'b0;
        st.double_flag   = 1'b0;
        st.long_flag     = 1'b0;
        st.click_pending = 1'b0;
        st.click_stamp   = '0;
        st.press_stamp   = '0;
        st.long_armed    = 1'b0;
      end
      // debounce: any raw change restarts the timer
      if (it.button_level != st.prev_raw_level) st.change_stamp = it.now_ms;
      age = it.now_ms - st.change_stamp;
      if (age > widen(cfg.debounce_time) && it.button_level != st.steady_level) begin
        st.steady_level = it.button_level;
        if (it.button_level == bgc_pkg::LVL_PRESSED) begin
          st.press_stamp = it.now_ms;
          st.long_armed  = 1'b1;
          age = it.now_ms - st.click_stamp;
          if (st.click_pending && age < widen(cfg.double_click_window)) begin
            st.double_flag   = 1'b1;
            st.click_pending = 1'b0;
            st.click_stamp   = '0;
          end else begin
            st.click_pending = 1'b1;
            st.click_stamp   = it.now_ms;
          end
        end
      end
      // long press drops any pending click
      age = it.now_ms - st.press_stamp;
      if (st.steady_level == bgc_pkg::LVL_PRESSED && st.long_armed &&
          age >= widen(cfg.long_press_time)) begin
        st.long_flag     = 1'b1;
        st.click_pending = 1'b0;
        st.long_armed    = 1'b0;
        st.press_stamp   = '0;
      end
      // single click confirmed once released and the window expired
      age = it.now_ms - st.click_stamp;
      if (st.click_pending && st.steady_level == bgc_pkg::LVL_RELEASED &&
          age >= widen(cfg.double_click_window)) begin
        st.click_flag    = 1'b1;
        st.click_pending = 1'b0;
      end
      st.prev_raw_level = it.button_level;

      res.click_event        = st.click_flag;
      res.double_click_event = st.double_flag;
      res.long_press_event   = st.long_flag;
      res.debounced_level    = st.steady_level;
      expected_flags.push_back(res);
    endfunction

    function void compare_bit(input string name, input logic want, input logic got);
      if (got !== want) begin
        $error("%s mismatch: expected %0b, got %0b", name, want, got);
        errors++;
      end
    endfunction

    // compare one result item against the oldest expectation
    function void check_flags(input logic [bgc_pkg::OUT_TDATA_W-1:0] data);
      flags_t want;
      flags_t got;
      if (expected_flags.size() == 0) begin
        $error("result item with nothing outstanding: out_tdata=%h", data);
        errors++;
        return;
      end
      want = expected_flags.pop_front();
      got  = flags_t'(data[3:0]);
      compare_bit("click_event", want.click_event, got.click_event);
      compare_bit("double_click_event", want.double_click_event, got.double_click_event);
      compare_bit("long_press_event", want.long_press_event, got.long_press_event);
      compare_bit("debounced_level", want.debounced_level, got.debounced_level);
    endfunction
  endclass

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            cfg_wr_en  = 1'b0;
  logic [bgc_pkg::CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [bgc_pkg::CFG_DATA_W-1:0]  cfg_wdata  = '0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  // [0] button_level, [32:1] now_ms, [33] ack_click, [34] ack_double,
  // [35] ack_long, [36] clear_all, [39:37] zero
  logic [bgc_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  // [0] click_event, [1] double_click_event, [2] long_press_event,
  // [3] debounced_level, [7:4] zero
  logic [bgc_pkg::OUT_TDATA_W-1:0] out_tdata;

  gesture_scoreboard sb = new();
  bit                no_idle    = 1'b0;
  int unsigned       polls_sent = 0;
  int unsigned       clock_ms   = 0;
  logic              raw_lvl    = bgc_pkg::LVL_RELEASED;
  int unsigned       stall_left = 0;

  button_gesture_classifier dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mostly no gap, some short ones, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // a duration at or just around a threshold, sometimes anywhere up to twice it plus two
  function automatic int unsigned near(input int unsigned base);
    case ($urandom_range(0, 3))
      0:       return (base > 0) ? base - 1 : 0;
      1:       return base;
      2:       return base + 1;
      default: return $urandom_range(0, 2 * base + 2);
    endcase
  endfunction

  function automatic bgc_pkg::item_t mk(input logic lvl,
                                        input logic [bgc_pkg::STAMP_W-1:0] now,
                                        input logic [3:0] ctl);
    bgc_pkg::item_t it;
    // ctl is {clear_all, ack_long, ack_double, ack_click}
    it.button_level = lvl;
    it.now_ms       = now;
    it.ack_click    = ctl[0];
    it.ack_double   = ctl[1];
    it.ack_long     = ctl[2];
    it.clear_all    = ctl[3];
    return it;
  endfunction

  // result side: random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      stall_left <= no_idle ? 0 : pick_gap();
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_flags(out_tdata);
  end

  // send one item and record it once accepted
  task automatic push_poll(input bgc_pkg::item_t it);
    int unsigned gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(bgc_pkg::IN_TDATA_W-$bits(bgc_pkg::item_t)){1'b0}}, it};
    do @(posedge clk); while (!in_tready);
    sb.note_poll(it);
    polls_sent++;
  endtask

  // poll at a later time with occasional acknowledges and clears
  task automatic poll(input logic lvl, input int unsigned delta);
    logic [3:0] ctl;
    clock_ms = clock_ms + delta;
    raw_lvl  = lvl;
    ctl[0]   = ($urandom_range(0, 5) == 0);
    ctl[1]   = ($urandom_range(0, 5) == 0);
    ctl[2]   = ($urandom_range(0, 5) == 0);
    ctl[3]   = ($urandom_range(0, 39) == 0);
    push_poll(mk(lvl, clock_ms, ctl));
  endtask

  // keep a raw level for about dur ms, sampled a few times
  task automatic hold_level(input logic lvl, input int unsigned dur);
    int unsigned n;
    int unsigned left;
    int unsigned delta;
    n    = $urandom_range(1, 3);
    left = dur;
    poll(lvl, $urandom_range(1, 3));
    for (int i = 0; i < n; i++) begin
      delta = left / (n - i) + $urandom_range(0, 2);
      poll(lvl, delta);
      left = (delta > left) ? 0 : left - delta;
    end
    if ($urandom_range(0, 2) == 0) poll(lvl, 1);
  endtask

  // random gestures until count more items were accepted
  task automatic run_gestures(input int unsigned count);
    int unsigned    start;
    int unsigned    d;
    int unsigned    w;
    int unsigned    lp;
    logic [63:0]    raw64;
    bgc_pkg::item_t it;
    start = polls_sent;
    while (polls_sent - start < count) begin
      d  = sb.cfg.debounce_time;
      w  = sb.cfg.double_click_window;
      lp = sb.cfg.long_press_time;
      if ($urandom_range(0, 19) == 0) no_idle = !no_idle;
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // single click
          hold_level(bgc_pkg::LVL_PRESSED, d + 1 + $urandom_range(0, lp / 2));
          hold_level(bgc_pkg::LVL_RELEASED, d + 1 + near(w));
        end
        3, 4: begin
          // double click attempt
          hold_level(bgc_pkg::LVL_PRESSED, d + 1 + $urandom_range(0, w / 2));
          hold_level(bgc_pkg::LVL_RELEASED, d + 1 + $urandom_range(0, w / 2));
          hold_level(bgc_pkg::LVL_PRESSED, d + 1 + near(lp));
          hold_level(bgc_pkg::LVL_RELEASED, d + 1 + near(w));
        end
        5, 6: begin
          // long press
          hold_level(bgc_pkg::LVL_PRESSED, d + 1 + near(lp));
          hold_level(bgc_pkg::LVL_RELEASED, d + 1 + near(w));
        end
        7: begin
          // contact bounce no longer than the debounce time
          repeat ($urandom_range(1, 4)) poll(!raw_lvl, $urandom_range(0, d));
        end
        8: begin
          // fully random item
          raw64    = {$urandom, $urandom};
          it       = bgc_pkg::item_t'(raw64[$bits(bgc_pkg::item_t)-1:0]);
          clock_ms = it.now_ms;
          raw_lvl  = it.button_level;
          push_poll(it);
        end
        default: begin
          // timestamp jumps backwards or anywhere
          if ($urandom_range(0, 1) == 0) clock_ms = clock_ms - $urandom_range(1, 2 * w + 2);
          else clock_ms = $urandom;
          poll(raw_lvl, 0);
        end
      endcase
    end
  endtask

  // wait until every item has its result, then let the pipeline settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.expected_flags.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_regs(input logic [bgc_pkg::CFG_DATA_W-1:0] d,
                          input logic [bgc_pkg::CFG_DATA_W-1:0] w,
                          input logic [bgc_pkg::CFG_DATA_W-1:0] lp);
    cfg_wr_en <= 1'b1;
    cfg_index <= bgc_pkg::CFG_DEBOUNCE_TIME;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_index <= bgc_pkg::CFG_DOUBLE_WINDOW;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= bgc_pkg::CFG_LONG_PRESS_TIME;
    cfg_wdata <= lp;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.cfg.debounce_time       = d;
    sb.cfg.double_click_window = w;
    sb.cfg.long_press_time     = lp;
  endtask

  task automatic run_phase(input logic [bgc_pkg::CFG_DATA_W-1:0] d,
                           input logic [bgc_pkg::CFG_DATA_W-1:0] w,
                           input logic [bgc_pkg::CFG_DATA_W-1:0] lp,
                           input int unsigned count);
    drain();
    set_regs(d, w, lp);
    run_gestures(count);
  endtask

  // watchdog
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed items under reset register values
    push_poll(mk(bgc_pkg::LVL_RELEASED, 32'd0, 4'b0000));
    push_poll(mk(bgc_pkg::LVL_PRESSED, 32'd10, 4'b0111));
    push_poll(mk(bgc_pkg::LVL_PRESSED, 32'd61, 4'b0000));   // press accepted
    push_poll(mk(bgc_pkg::LVL_RELEASED, 32'd100, 4'b0000));
    push_poll(mk(bgc_pkg::LVL_RELEASED, 32'd151, 4'b0000)); // release accepted
    push_poll(mk(bgc_pkg::LVL_PRESSED, 32'd200, 4'b0000));
    push_poll(mk(bgc_pkg::LVL_PRESSED, 32'd251, 4'b0000));  // double click
    push_poll(mk(bgc_pkg::LVL_PRESSED, 32'd1251, 4'b0000)); // long press after double
    push_poll(mk(bgc_pkg::LVL_RELEASED, 32'd1300, 4'b0000));
    push_poll(mk(bgc_pkg::LVL_RELEASED, 32'd1400, 4'b0000));
    push_poll(mk(bgc_pkg::LVL_RELEASED, 32'd1401, 4'b1111)); // acks together with clear
    push_poll(mk(bgc_pkg::LVL_PRESSED, 32'hFFFF_FFF0, 4'b0000));
    push_poll(mk(bgc_pkg::LVL_PRESSED, 32'h0000_0030, 4'b0000)); // press across the wrap
    push_poll(mk(bgc_pkg::LVL_RELEASED, 32'h0000_0040, 4'b0000));
    push_poll(mk(bgc_pkg::LVL_RELEASED, 32'h0000_0080, 4'b0000));
    push_poll(mk(bgc_pkg::LVL_RELEASED, 32'h0000_0200, 4'b0000)); // single click
    push_poll(mk(bgc_pkg::LVL_PRESSED, 32'h0000_0100, 4'b0000));  // time runs backwards
    push_poll(mk(bgc_pkg::LVL_PRESSED, 32'h0000_0050, 4'b0000));
    push_poll(mk(bgc_pkg::LVL_PRESSED, 32'h0000_0010, 4'b0000));
    push_poll(mk(bgc_pkg::LVL_RELEASED, 32'hFFFF_FFFF, 4'b1001));
    push_poll(mk(bgc_pkg::LVL_RELEASED, 32'hFFFF_FFFF, 4'b1111));
    push_poll(mk(bgc_pkg::LVL_RELEASED, 32'd0, 4'b0000));
    clock_ms = 0;
    raw_lvl  = bgc_pkg::LVL_RELEASED;
    run_gestures(60);

    // zero times, all maximum, small, random, mixed extremes
    run_phase(16'd0, 16'd0, 16'd0, 60);
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 60);
    run_phase(16'd3, 16'd20, 16'd60, 80);
    run_phase(16'($urandom_range(0, 200)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)), 70);
    run_phase(16'd0, 16'hFFFF, 16'd1, 60);

    drain();
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
design/bgc_pkg.sv
design/bgc_step.sv
design/button_gesture_classifier.sv
test/button_gesture_classifier_tb.sv
